>>> rtl/rlkf_pkg.sv
// ----------------------------------------------------------------------------
// Reverse line keyword filter package
// Shared widths, register indexes and the window cell control struct.
// ----------------------------------------------------------------------------
package rlkf_pkg;

	localparam int KEY_BYTES   = 16;
	localparam int KEY_LEN_W   = 5;
	localparam int OFFSET_BITS = 32;
	localparam int END_BITS    = OFFSET_BITS + 1;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEYWORD_LOW    = 2'd0,
		REG_KEYWORD_HIGH   = 2'd1,
		REG_KEYWORD_LENGTH = 2'd2,
		REG_MAX_MATCHES    = 2'd3
	} cfg_reg_t;

	// Per-cycle command broadcast to every window cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

>>> rtl/reverse_line_keyword_filter_top.sv
// ----------------------------------------------------------------------------
// Reverse line keyword filter
// Finds lines holding a fixed keyword while the file streams in backward.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and reports a matching line in the
// cycle after the transfer that closes it (the preceding newline or the
// file-start byte). The lookahead window is a row of MAX_KEY cells that
// shift on every non-newline byte; all cells compare against the keyword
// at once, so the whole keyword test fits in the cycle of the byte that
// starts it. A one-entry output register holds each result; input transfers
// go on back to back and stall only while a result waits for out_ready.
// After the match limit or the file-start byte, further input is taken and
// dropped. Configuration writes must happen while the block is idle.
module reverse_line_keyword_filter_top #(
	parameter int MAX_KEY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rlkf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rlkf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           data_byte,
	input  logic [rlkf_pkg::OFFSET_BITS-1:0]     byte_offset,
	input  logic                                 is_file_start,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rlkf_pkg::OFFSET_BITS-1:0]     line_start,
	output logic [rlkf_pkg::END_BITS-1:0]        line_end,
	output logic                                 search_done
);
	import rlkf_pkg::*;

	localparam logic [KEY_LEN_W-1:0] MAX_KEY_N = KEY_LEN_W'(MAX_KEY);

	// Configuration registers
	logic [63:0]          keyword_low_q;
	logic [63:0]          keyword_high_q;
	logic [KEY_LEN_W-1:0] keyword_length_q;
	logic [7:0]           max_matches_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_low_q    <= '0;
			keyword_high_q   <= '0;
			keyword_length_q <= KEY_LEN_W'(1);
			max_matches_q    <= 8'd5;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEYWORD_LOW:    keyword_low_q    <= cfg_data;
				REG_KEYWORD_HIGH:   keyword_high_q   <= cfg_data;
				REG_KEYWORD_LENGTH: keyword_length_q <= cfg_data[KEY_LEN_W-1:0];
				REG_MAX_MATCHES:    max_matches_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic [8*KEY_BYTES-1:0] key_bytes;
	logic [KEY_LEN_W-1:0]   key_n;
	logic [7:0]             limit;

	assign key_bytes = {keyword_high_q, keyword_low_q};

	always_comb begin
		key_n = keyword_length_q;
		if (key_n == '0) begin
			key_n = KEY_LEN_W'(1);
		end
		if (key_n > MAX_KEY_N) begin
			key_n = MAX_KEY_N;
		end
		limit = (max_matches_q == 8'd0) ? 8'd1 : max_matches_q;
	end

	// Search state
	logic                   started_q;
	logic                   finished_q;
	logic                   line_matched_q;
	logic [END_BITS-1:0]    line_end_q;
	logic [7:0]             lines_found_q;

	logic                   out_valid_q;
	logic [OFFSET_BITS-1:0] line_start_q;
	logic [END_BITS-1:0]    line_end_out_q;
	logic                   search_done_q;

	logic accept;
	logic work;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign work     = accept && !finished_q;

	// Window cell row
	cell_ctl_t          ctl;
	logic [7:0]         chain_byte  [MAX_KEY+1];
	logic [MAX_KEY:0]   chain_valid;
	logic [MAX_KEY-1:0] cell_ok;
	logic               is_nl;

	assign is_nl          = data_byte == NEWLINE_CHAR;
	assign ctl.shift      = work && !is_nl;
	assign ctl.clear      = work && is_nl;
	assign chain_byte[0]  = data_byte;
	assign chain_valid[0] = 1'b1;

	for (genvar i = 0; i < MAX_KEY; i++) begin : g_cell
		logic [7:0] kb;
		logic       act;
		if (i + 1 < KEY_BYTES) begin : g_key
			assign kb  = key_bytes[8*(i+1) +: 8];
			assign act = KEY_LEN_W'(i + 1) < key_n;
		end else begin : g_nokey
			assign kb  = 8'h00;
			assign act = 1'b0;
		end
		rlkf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_byte  (chain_byte[i]),
			.prev_valid (chain_valid[i]),
			.key_byte   (kb),
			.active     (act),
			.cell_byte  (chain_byte[i+1]),
			.cell_valid (chain_valid[i+1]),
			.ok         (cell_ok[i])
		);
	end

	// Line bookkeeping for the byte in this transfer
	logic [END_BITS-1:0]    off_ext;
	logic [END_BITS-1:0]    off_plus1;
	logic [END_BITS-1:0]    cur_end;
	logic                   match;
	logic                   matched_now;
	logic                   emit;
	logic                   done;
	logic [7:0]             found_next;
	logic [OFFSET_BITS-1:0] start_val;

	always_comb begin
		off_ext     = {1'b0, byte_offset};
		off_plus1   = off_ext + END_BITS'(1);
		cur_end     = started_q ? line_end_q : off_plus1;
		match       = !is_nl && (data_byte == key_bytes[7:0]) && (&cell_ok);
		matched_now = line_matched_q || match;
		emit        = is_nl ? line_matched_q : (is_file_start && matched_now);
		start_val   = is_nl ? off_plus1[OFFSET_BITS-1:0] : byte_offset;
		found_next  = lines_found_q + {7'd0, emit};
		done        = (emit && (found_next >= limit)) || is_file_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q      <= 1'b0;
			finished_q     <= 1'b0;
			line_matched_q <= 1'b0;
			line_end_q     <= '0;
			lines_found_q  <= '0;
		end else if (work) begin
			started_q      <= 1'b1;
			finished_q     <= done;
			lines_found_q  <= found_next;
			line_end_q     <= is_nl ? off_ext : cur_end;
			line_matched_q <= is_nl ? 1'b0 : (matched_now && !is_file_start);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work && (emit || done)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (work && (emit || done)) begin
			line_start_q   <= emit ? start_val : '0;
			line_end_out_q <= emit ? cur_end : '0;
			search_done_q  <= done;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_start  = line_start_q;
	assign line_end    = line_end_out_q;
	assign search_done = search_done_q;

endmodule

>>> rtl/rlkf_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one byte of the lookahead window, hands it to its neighbor on every
// shift and checks it against its keyword byte.
// ----------------------------------------------------------------------------
module rlkf_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rlkf_pkg::cell_ctl_t ctl,
	input  logic [7:0]        prev_byte,
	input  logic              prev_valid,
	input  logic [7:0]        key_byte,
	input  logic              active,
	output logic [7:0]        cell_byte,
	output logic              cell_valid,
	output logic              ok
);
	import rlkf_pkg::*;

	logic [7:0] byte_q;
	logic       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= prev_byte;
		end
	end

	// A cell beyond the keyword length never blocks a match.
	assign ok         = !active || (valid_q && (byte_q == key_byte));
	assign cell_byte  = byte_q;
	assign cell_valid = valid_q;

endmodule

>>> rtl/rlkf_checker.sv
// ----------------------------------------------------------------------------
// Reverse line keyword filter checker
// Port-level checks on the filter's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module rlkf_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_we,
	input logic [rlkf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input logic [rlkf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic [7:0]                           data_byte,
	input logic [rlkf_pkg::OFFSET_BITS-1:0]     byte_offset,
	input logic                                 is_file_start,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [rlkf_pkg::OFFSET_BITS-1:0]     line_start,
	input logic [rlkf_pkg::END_BITS-1:0]        line_end,
	input logic                                 search_done
);
	import rlkf_pkg::*;

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_start)
			&& $stable(line_end) && $stable(search_done))
		else $error("result changed while stalled");

	// Once the final result is transferred, the block stays silent.
	a_quiet_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && search_done |=> !out_valid)
		else $error("result after search finished");

	// The input side only waits on a stalled result.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled without a pending result");

endmodule

bind reverse_line_keyword_filter_top rlkf_checker u_rlkf_checker (.*);

>>> test/reverse_line_keyword_filter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reverse line keyword filter testbench
// Streams files backward as lines of bytes, predicts each reported line from
// its own model of the keyword window and line bookkeeping, and compares
// every output transfer field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module reverse_line_keyword_filter_top_tb;
	import rlkf_pkg::*;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] line_start;
		logic [END_BITS-1:0]    line_end;
		logic                   search_done;
	} line_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = '0;
	logic [OFFSET_BITS-1:0] byte_offset = '0;
	logic is_file_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [OFFSET_BITS-1:0] line_start;
	logic [END_BITS-1:0] line_end;
	logic search_done;

	// Predicted state of the filter and its register copies.
	logic [63:0] kw_low = '0;
	logic [63:0] kw_high = '0;
	logic [KEY_LEN_W-1:0] kw_len = 5'd1;
	logic [7:0] match_limit = 8'd5;
	logic [7:0] look_win [KEY_BYTES];
	int unsigned win_fill = 0;
	bit line_hit = 0;
	logic [END_BITS-1:0] line_end_cur = '0;
	bit seen_first = 0;
	logic [7:0] hits = '0;
	bit search_over = 0;

	line_report_t expected_lines[$];
	line_report_t want;
	logic [7:0] line_buf[$];
	logic [OFFSET_BITS-1:0] next_off = '1;
	int items_sent = 0;
	int mismatches = 0;
	bit tx_gaps = 1;
	int burst_left = 0;
	int rx_left = 0;
	int rx_phase_left = 0;
	bit rx_choppy = 0;

	reverse_line_keyword_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.byte_offset(byte_offset),
		.is_file_start(is_file_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_start(line_start),
		.line_end(line_end),
		.search_done(search_done)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] keyword_byte(input int i);
		if (i < 8)
			return kw_low[8*i +: 8];
		return kw_high[8*(i-8) +: 8];
	endfunction

	function automatic int eff_key_len();
		if (kw_len == 0)
			return 1;
		if (kw_len > KEY_BYTES)
			return KEY_BYTES;
		return kw_len;
	endfunction

	function automatic void predict_line_report(input logic [7:0] b,
			input logic [OFFSET_BITS-1:0] off, input logic at_start);
		line_report_t r;
		bit emit;
		bit done;
		bit hit;
		int n;
		int limit;
		int i;
		if (search_over)
			return;
		limit = (match_limit == 0) ? 1 : match_limit;
		emit = 0;
		done = 0;
		r = '0;
		if (!seen_first) begin
			seen_first = 1;
			line_end_cur = {1'b0, off} + 1'b1;
		end
		if (b == NEWLINE_CHAR) begin
			if (line_hit) begin
				emit = 1;
				r.line_start = off + 1'b1;
				r.line_end = line_end_cur;
			end
			line_end_cur = {1'b0, off};
			line_hit = 0;
			win_fill = 0;
		end else begin
			n = eff_key_len();
			hit = (b == keyword_byte(0)) && (win_fill >= n - 1);
			for (i = 1; i < n; i++)
				if (look_win[i-1] != keyword_byte(i))
					hit = 0;
			if (hit)
				line_hit = 1;
			for (i = KEY_BYTES - 1; i > 0; i--)
				look_win[i] = look_win[i-1];
			look_win[0] = b;
			if (win_fill < KEY_BYTES)
				win_fill++;
			// The file-start byte closes the line it belongs to.
			if (at_start && line_hit) begin
				emit = 1;
				r.line_start = off;
				r.line_end = line_end_cur;
				line_hit = 0;
			end
		end
		if (emit) begin
			hits = hits + 1'b1;
			if (hits >= limit)
				done = 1;
		end
		if (at_start)
			done = 1;
		if (emit || done) begin
			if (done)
				search_over = 1;
			r.search_done = done;
			expected_lines.push_back(r);
		end
	endfunction

	// Receiver: ready follows runs of random length, with calm stretches.
	always @(negedge clk) begin
		if (rx_phase_left == 0) begin
			rx_phase_left = $urandom_range(100, 400);
			rx_choppy = ($urandom_range(0, 2) != 0);
		end else
			rx_phase_left--;
		if (rx_left == 0) begin
			rx_left = $urandom_range(1, 6);
			out_ready <= !rx_choppy || ($urandom_range(0, 1) == 1);
		end else
			rx_left--;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_lines.size() == 0) begin
				$error("unexpected result transfer: line_start %0h line_end %0h search_done %0b",
					line_start, line_end, search_done);
				mismatches++;
			end else begin
				want = expected_lines.pop_front();
				if (line_start !== want.line_start) begin
					$error("line_start: expected %0h, got %0h", want.line_start, line_start);
					mismatches++;
				end
				if (line_end !== want.line_end) begin
					$error("line_end: expected %0h, got %0h", want.line_end, line_end);
					mismatches++;
				end
				if (search_done !== want.search_done) begin
					$error("search_done: expected %0b, got %0b", want.search_done, search_done);
					mismatches++;
				end
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic [OFFSET_BITS-1:0] off,
			input logic at_start);
		int gap;
		if (tx_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		byte_offset <= off;
		is_file_start <= at_start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_line_report(b, off, at_start);
		items_sent++;
	endtask

	// Drops valid and waits for every pending result plus the block's latency.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (which)
			REG_KEYWORD_LOW:    kw_low = val;
			REG_KEYWORD_HIGH:   kw_high = val;
			REG_KEYWORD_LENGTH: kw_len = val[KEY_LEN_W-1:0];
			REG_MAX_MATCHES:    match_limit = val[7:0];
			default: ;
		endcase
	endtask

	// Fills line_buf with one line in file order, optionally holding the keyword.
	task automatic build_line(input int len, input bit with_key);
		int n;
		int i;
		int pos;
		logic [7:0] b;
		n = eff_key_len();
		line_buf.delete();
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0)
				b = keyword_byte($urandom_range(0, n - 1));
			else begin
				b = 8'($urandom);
				if (b == NEWLINE_CHAR)
					b = 8'h20;
			end
			line_buf.push_back(b);
		end
		if (with_key && len >= n) begin
			pos = $urandom_range(0, len - n);
			for (i = 0; i < n; i++)
				line_buf[pos + i] = keyword_byte(i);
		end
	endtask

	// Sends line_buf backward, then the newline before it unless it opens the file.
	task automatic send_line(input bit last_line);
		int i;
		for (i = line_buf.size() - 1; i >= 0; i--) begin
			send_item(line_buf[i], next_off, last_line && i == 0);
			next_off--;
		end
		if (!last_line) begin
			send_item(NEWLINE_CHAR, next_off, 1'b0);
			next_off--;
		end
	endtask

	// Reset settings, first byte at the top offset so the line end needs 33 bits.
	task automatic test_first_byte();
		next_off = '1;
		line_buf = '{8'h00};
		send_line(0);
		settle();
		cfg_write(REG_MAX_MATCHES, '1);
	endtask

	task automatic test_zero_key_length();
		logic [63:0] val;
		cfg_write(REG_KEYWORD_LOW, {$urandom, $urandom} | 64'hFF);
		val = {$urandom, $urandom};
		val[KEY_LEN_W-1:0] = '0;
		cfg_write(REG_KEYWORD_LENGTH, val);
		build_line(1, 1);
		send_line(0);
		settle();
	endtask

	// A keyword that holds a newline can never match across lines.
	task automatic test_newline_in_keyword();
		logic [63:0] val;
		val = {$urandom, $urandom};
		val[15:0] = {NEWLINE_CHAR, 8'h61};
		cfg_write(REG_KEYWORD_LOW, val);
		cfg_write(REG_KEYWORD_LENGTH, 64'd2);
		line_buf.delete();
		send_line(0);
		line_buf = '{8'h61};
		send_line(0);
		settle();
	endtask

	task automatic test_full_keyword();
		logic [63:0] val;
		cfg_write(REG_KEYWORD_LOW, {$urandom, $urandom} | 64'h8080_8080_8080_8080);
		cfg_write(REG_KEYWORD_HIGH, {$urandom, $urandom} | 64'h8080_8080_8080_8080);
		val = {$urandom, $urandom};
		val[KEY_LEN_W-1:0] = 5'd31;
		cfg_write(REG_KEYWORD_LENGTH, val);
		build_line(KEY_BYTES, 1);
		send_line(0);
		settle();
	endtask

	task automatic test_random_lines();
		int phase;
		int stop_at;
		int n;
		int len;
		int floor_v;
		bit with_key;
		logic [63:0] val;
		for (phase = 0; phase < 6; phase++) begin
			if (search_over)
				break;
			settle();
			cfg_write(REG_KEYWORD_LOW, {$urandom, $urandom});
			cfg_write(REG_KEYWORD_HIGH, {$urandom, $urandom});
			val = {$urandom, $urandom};
			case ($urandom_range(0, 5))
				0: val[KEY_LEN_W-1:0] = 5'd16;
				1: val[KEY_LEN_W-1:0] = 5'd0;
				2: val[KEY_LEN_W-1:0] = 5'($urandom_range(17, 31));
				default: val[KEY_LEN_W-1:0] = 5'($urandom_range(1, 4));
			endcase
			cfg_write(REG_KEYWORD_LENGTH, val);
			// Keep the match limit well above the count so the search goes on.
			floor_v = int'(hits) + 40;
			if (floor_v > 255)
				floor_v = 255;
			val = {$urandom, $urandom};
			val[7:0] = 8'($urandom_range(floor_v, 255));
			cfg_write(REG_MAX_MATCHES, val);
			tx_gaps = (phase % 3) != 0;
			n = eff_key_len();
			stop_at = items_sent + 250;
			while (items_sent < stop_at && !search_over) begin
				with_key = $urandom_range(0, 4) < 2;
				len = with_key ? n + $urandom_range(0, 12) : $urandom_range(0, 20);
				if ($urandom_range(0, 7) == 0)
					next_off = $urandom;
				build_line(len, with_key);
				send_line(0);
			end
		end
		tx_gaps = 1;
	endtask

	// Ends the search either on the match limit or on the file-start byte.
	task automatic test_search_end();
		int mode;
		int n;
		logic [63:0] val;
		if (search_over)
			return;
		mode = $urandom_range(0, 3);
		settle();
		n = eff_key_len();
		if (mode < 2) begin
			val = {$urandom, $urandom};
			val[7:0] = 8'(mode);
			cfg_write(REG_MAX_MATCHES, val);
			build_line(n + 3, 1);
			send_line(0);
		end else begin
			cfg_write(REG_MAX_MATCHES, 64'hFF);
			build_line(n + $urandom_range(0, 6), mode == 2);
			if ($urandom_range(0, 3) == 0)
				line_buf.push_front(NEWLINE_CHAR);
			next_off = line_buf.size() - 1;
			send_line(1);
		end
		settle();
	endtask

	// Once the search is over, every byte is taken and dropped.
	task automatic test_after_done();
		int i;
		for (i = 0; i < 3; i++)
			send_item(8'($urandom), $urandom, 1'b0);
		send_item(8'($urandom), '0, 1'b1);
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_first_byte();
		test_zero_key_length();
		test_newline_in_keyword();
		test_full_keyword();
		test_random_lines();
		test_search_end();
		test_after_done();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_lines.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> reverse_line_keyword_filter_top.f
rtl/rlkf_pkg.sv
rtl/rlkf_cell.sv
rtl/reverse_line_keyword_filter_top.sv
rtl/rlkf_checker.sv
test/reverse_line_keyword_filter_top_tb.sv
